@@ rtl/mts_pkg.sv @@
// Shared types and constants of the min-tracking stack.
package mts_pkg;

    localparam int DEPTH   = 256;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 9;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    // Shift command for one row of cells
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_op;

endpackage

@@ rtl/mts_if.sv @@
// Handshake channels for operation items and result items.
interface mts_in_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [ENTRY_W-1:0]       entry_count;
    logic [1:0]               status;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input top_value, input min_value, input is_empty,
                    input entry_count, input status, output ready);
endinterface

@@ rtl/min_tracking_stack_top.sv @@
// Min-tracking stack: value row, minima row and result register.
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          kind, value
//  o_res     out  valid/ready          top_value, min_value, is_empty, entry_count, status
//
// One item per cycle unless the result stalls; a legal push or pop shifts the value row.
// The result for an item appears in the result register the cycle after acceptance.
// Reset clears both fill counts and the result valid; cell contents stay undefined.
// A stalled result holds the register; a new item is taken in the cycle the result leaves.
module min_tracking_stack_top import mts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mts_in_if.sink     i_in,
    mts_out_if.source  o_res
);

    logic                     w_take;
    logic                     w_is_push;
    logic                     w_push_ok;
    logic                     w_pop_ok;
    logic                     w_min_push;
    logic                     w_min_pop;
    t_shift_op                w_val_op;
    t_shift_op                w_min_op;
    t_status                  w_status;
    logic signed [DATA_W-1:0] w_val_top;
    logic signed [DATA_W-1:0] w_val_next_top;
    logic signed [DATA_W-1:0] w_min_top;
    logic signed [DATA_W-1:0] w_min_next_top;
    logic [CNT_W-1:0]         w_val_cnt;
    logic [CNT_W-1:0]         w_val_next_cnt;
    logic [CNT_W-1:0]         w_min_cnt;
    logic [CNT_W-1:0]         w_min_next_cnt;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_top_value;
    logic signed [DATA_W-1:0] r_min_value;
    logic                     r_is_empty;
    logic [ENTRY_W-1:0]       r_entry_count;
    t_status                  r_status;

    // Accept when the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_is_push  = (i_in.kind == KIND_PUSH);

    // Decide the shift of each row
    always_comb begin
        w_push_ok  = w_take && w_is_push && (w_val_cnt != CNT_W'(DEPTH));
        w_pop_ok   = w_take && !w_is_push && (w_val_cnt != '0);
        w_min_push = w_push_ok &&
                     ((w_min_cnt == '0) ||
                      ((w_min_cnt < CNT_W'(DEPTH)) && (i_in.value <= w_min_top)));
        w_min_pop  = w_pop_ok && (w_min_cnt != '0) && (w_min_top == w_val_top);

        w_val_op.push = w_push_ok;
        w_val_op.pop  = w_pop_ok;
        w_min_op.push = w_min_push;
        w_min_op.pop  = w_min_pop;

        if (w_is_push) begin
            w_status = (w_val_cnt == CNT_W'(DEPTH)) ? ST_PUSH_FULL : ST_DONE;
        end else begin
            w_status = (w_val_cnt == '0) ? ST_POP_EMPTY : ST_DONE;
        end
    end

    mts_chain u_val_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_val_op),
        .i_push_value (i_in.value),
        .o_top        (w_val_top),
        .o_next_top   (w_val_next_top),
        .o_count      (w_val_cnt),
        .o_next_count (w_val_next_cnt)
    );

    mts_chain u_min_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_min_op),
        .i_push_value (i_in.value),
        .o_top        (w_min_top),
        .o_next_top   (w_min_next_top),
        .o_count      (w_min_cnt),
        .o_next_count (w_min_next_cnt)
    );

    // Hold the result flag until the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the post-operation view of both rows
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_top_value   <= (w_val_next_cnt != '0) ? w_val_next_top : EMPTY_VALUE;
            r_min_value   <= (w_min_next_cnt != '0) ? w_min_next_top : EMPTY_VALUE;
            r_is_empty    <= (w_val_next_cnt == '0);
            r_entry_count <= ENTRY_W'(w_val_next_cnt);
            r_status      <= w_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.top_value   = r_top_value;
    assign o_res.min_value   = r_min_value;
    assign o_res.is_empty    = r_is_empty;
    assign o_res.entry_count = r_entry_count;
    assign o_res.status      = r_status;

    a_min_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_min_cnt <= w_val_cnt)
        else $error("minima row deeper than value row");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_min_cnt == '0) == (w_val_cnt == '0))
        else $error("minima row and value row disagree on empty");

    a_result_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("accepted item gave no result");

endmodule

@@ rtl/mts_cell.sv @@
// One stack cell: holds one entry and shifts with its neighbors.
module mts_cell import mts_pkg::*; (
    input  logic                     i_clk,
    input  t_shift_op                i_op,
    input  logic signed [DATA_W-1:0] i_from_above,
    input  logic signed [DATA_W-1:0] i_from_below,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_next_value
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // Take from above on push, from below on pop, else hold
    always_comb begin
        if (i_op.push) begin
            n_value = i_from_above;
        end else if (i_op.pop) begin
            n_value = i_from_below;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

@@ rtl/mts_chain.sv @@
// Row of stack cells with its fill count; cell 0 is the top.
module mts_chain import mts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_shift_op                i_op,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic signed [DATA_W-1:0] o_top,
    output logic signed [DATA_W-1:0] o_next_top,
    output logic [CNT_W-1:0]         o_count,
    output logic [CNT_W-1:0]         o_next_count
);

    logic signed [DATA_W-1:0] w_value [DEPTH];
    logic signed [DATA_W-1:0] w_next  [DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    // Build the row; the bottom cell refills from itself on pop
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_above;
        logic signed [DATA_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_value;
        end else begin : g_inner_above
            assign w_above = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_below = w_value[g];
        end else begin : g_inner_below
            assign w_below = w_value[g+1];
        end

        mts_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_value      (w_value[g]),
            .o_next_value (w_next[g])
        );
    end

    // Advance the fill count with the shift
    always_comb begin
        n_count = r_count;
        if (i_op.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top        = w_value[0];
    assign o_next_top   = w_next[0];
    assign o_count      = r_count;
    assign o_next_count = n_count;

    a_one_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_op.push && i_op.pop))
        else $error("push and pop requested together");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.push |-> (r_count != CNT_W'(DEPTH)))
        else $error("push into a full row");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.pop |-> (r_count != '0))
        else $error("pop from an empty row");

endmodule
